// File: hdl/qnpc_pkg.sv
// Shared types and constants for the quad near-plane clipper.
package qnpc_pkg;

    localparam int unsigned MAX_OUT = 5;
    localparam int unsigned T_FRAC = 30;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_DEPTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_EPS = 1'b1;

    localparam logic [30:0] NEAR_RESET = 31'd65536;
    localparam logic [15:0] EPS_RESET = 16'd7;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] corner_depth_in;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
    } corner_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_depth;
        logic [16:0]        out_u;
        logic [16:0]        out_v;
        logic               polygon_empty;
        logic               last_vertex;
        logic [2:0]         vertex_total;
    } result_t;

endpackage

// File: hdl/qnpc_div.sv
// Restoring divider, one quotient bit per cycle, for the crossing parameter t.
module qnpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [32:0] divisor,
    output logic        done,
    output logic [29:0] quot
);

    logic [33:0] rem_reg;
    logic [33:0] rem_sh;
    logic [32:0] dvs_reg;
    logic [29:0] q_reg;
    logic [4:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;

    assign rem_sh = {rem_reg[32:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(qnpc_pkg::T_FRAC);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, dividend};
            dvs_reg <= divisor;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= rem_sh - {1'b0, dvs_reg};
                q_reg   <= {q_reg[28:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                q_reg   <= {q_reg[28:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// File: hdl/qnpc_lerp.sv
// Two-stage interpolator: a + trunc((b - a) * t / 2^30).
module qnpc_lerp (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    input  logic [30:0]        t,
    output logic signed [31:0] res
);

    logic signed [32:0] diff;
    logic signed [63:0] prod_reg;
    logic signed [31:0] a_reg;
    logic signed [31:0] res_reg;
    logic signed [63:0] mag;
    logic signed [63:0] q;

    assign diff = 33'(a) ^ 33'(a) ^ ({b[31], b} - {a[31], a});

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(diff) * 64'($signed({1'b0, t}));
        a_reg    <= a;
        res_reg  <= a_reg + q[31:0];
    end

    // truncate toward zero
    always_comb
    begin
        mag = prod_reg[63] ? -prod_reg : prod_reg;
        q   = prod_reg[63] ? -(mag >>> qnpc_pkg::T_FRAC) : (mag >>> qnpc_pkg::T_FRAC);
    end

    assign res = res_reg;

endmodule

// File: hdl/quad_near_plane_clipper.sv
// Quad near-plane clipper: corner store, edge sequencer, shared divider and interpolator.
// A corner that does not close the polygon is only stored. The closing corner starts a walk:
// corner 0 is fetched and taken, then each edge is fetched, classified and posted; each
// crossing runs the interpolator for x, y, u and v, after the divider when t needs it. The
// results then go out back to back; busy stays high from the closing corner until the last
// result is out. Reset clears the corner count, the sequencer and the registers to 1.0 and 7.
module quad_near_plane_clipper #(
    parameter int POLY_CORNERS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  qnpc_pkg::corner_t                   corner,
    input  logic                                cfg_we,
    input  logic [qnpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [qnpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output logic                                result_valid,
    output qnpc_pkg::result_t                   result
);

    localparam int CW = $clog2(POLY_CORNERS);
    localparam logic [CW-1:0] LAST_IDX = CW'(POLY_CORNERS - 1);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b00000000001,
        S_FETCH_A = 11'b00000000010,
        S_TAKE_A  = 11'b00000000100,
        S_FETCH_B = 11'b00000001000,
        S_EDGE    = 11'b00000010000,
        S_DIV     = 11'b00000100000,
        S_MUL_I   = 11'b00001000000,
        S_MUL_W   = 11'b00010000000,
        S_MUL_ST  = 11'b00100000000,
        S_POST    = 11'b01000000000,
        S_EMIT    = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [30:0] near_reg;
    logic [15:0] eps_reg;

    qnpc_pkg::corner_t mem [POLY_CORNERS];
    qnpc_pkg::corner_t rd_q;
    qnpc_pkg::corner_t a_reg;
    qnpc_pkg::corner_t vbuf [qnpc_pkg::MAX_OUT];

    logic [CW-1:0] slot_reg;
    logic [CW-1:0] rd_addr_reg;
    logic [CW-1:0] edge_reg;
    logic [2:0]    n_reg;
    logic [2:0]    emit_reg;
    logic [1:0]    k_reg;
    logic          xin_reg;
    logic [30:0]   t_reg;

    logic signed [33:0] num;
    logic signed [33:0] den;
    logic [32:0]        an;
    logic [32:0]        ad;
    logic               cin;
    logic               xin;
    logic               t_zero;
    logic               need_div;
    logic               room;

    logic               div_start;
    logic               div_done;
    logic [29:0]        quot;
    logic signed [31:0] la;
    logic signed [31:0] lb;
    logic signed [31:0] lres;

    function automatic logic [CW-1:0] inc_idx(input logic [CW-1:0] i);
        inc_idx = (i == LAST_IDX) ? '0 : i + CW'(1);
    endfunction

    // config and corner store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg <= qnpc_pkg::NEAR_RESET;
            eps_reg  <= qnpc_pkg::EPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                qnpc_pkg::CFG_NEAR_DEPTH: near_reg <= cfg_wdata;
                qnpc_pkg::CFG_DEPTH_EPS:  eps_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
            mem[slot_reg] <= corner;
        rd_q <= mem[rd_addr_reg];
    end

    // edge classification and t special cases
    always_comb
    begin
        cin  = $signed(a_reg.corner_depth_in) > $signed({1'b0, near_reg});
        xin  = $signed(rd_q.corner_depth_in) > $signed({1'b0, near_reg});
        num  = $signed({3'b000, near_reg}) - 34'(a_reg.corner_depth_in);
        den  = 34'(rd_q.corner_depth_in) - 34'(a_reg.corner_depth_in);
        an   = num[33] ? 33'(-num) : num[32:0];
        ad   = den[33] ? 33'(-den) : den[32:0];
        t_zero = (ad <= {17'd0, eps_reg}) || (num == '0) || (num[33] != den[33]);
        need_div = !t_zero && (an < ad);
        room = n_reg < 3'(qnpc_pkg::MAX_OUT);
    end

    assign div_start = (state_reg == S_EDGE) && (cin != xin) && room && need_div;

    qnpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (an),
        .divisor  (ad),
        .done     (div_done),
        .quot     (quot)
    );

    always_comb
    begin
        case (k_reg)
            2'd0:    begin la = a_reg.pos_x; lb = rd_q.pos_x; end
            2'd1:    begin la = a_reg.pos_y; lb = rd_q.pos_y; end
            2'd2:    begin la = 32'(a_reg.tex_u); lb = 32'(rd_q.tex_u); end
            default: begin la = 32'(a_reg.tex_v); lb = 32'(rd_q.tex_v); end
        endcase
    end

    qnpc_lerp u_lerp (
        .clk (clk),
        .a   (la),
        .b   (lb),
        .t   (t_reg),
        .res (lres)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (start && slot_reg == LAST_IDX) state_next = S_FETCH_A;
            S_FETCH_A: state_next = S_TAKE_A;
            S_TAKE_A:  state_next = S_FETCH_B;
            S_FETCH_B: state_next = S_EDGE;
            S_EDGE:
            begin
                if (cin != xin && room)
                    state_next = need_div ? S_DIV : S_MUL_I;
                else
                    state_next = S_POST;
            end
            S_DIV:     if (div_done) state_next = S_MUL_I;
            S_MUL_I:   state_next = S_MUL_W;
            S_MUL_W:   state_next = S_MUL_ST;
            S_MUL_ST:  state_next = (k_reg == 2'd3) ? S_POST : S_MUL_I;
            S_POST:    state_next = (edge_reg == LAST_IDX) ? S_EMIT : S_FETCH_B;
            S_EMIT:
            begin
                if (n_reg == '0 || emit_reg == n_reg - 3'd1)
                    state_next = S_IDLE;
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            slot_reg    <= '0;
            rd_addr_reg <= '0;
            edge_reg    <= '0;
            n_reg       <= '0;
            emit_reg    <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        slot_reg <= inc_idx(slot_reg);
                        if (slot_reg == LAST_IDX)
                        begin
                            rd_addr_reg <= '0;
                            edge_reg    <= '0;
                            n_reg       <= '0;
                        end
                    end
                end
                S_TAKE_A: rd_addr_reg <= inc_idx(rd_addr_reg);
                S_EDGE:   k_reg <= '0;
                S_MUL_ST:
                begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                        n_reg <= n_reg + 3'd1;
                end
                S_POST:
                begin
                    if (xin_reg && room)
                        n_reg <= n_reg + 3'd1;
                    if (edge_reg == LAST_IDX)
                        emit_reg <= '0;
                    else
                    begin
                        rd_addr_reg <= inc_idx(rd_addr_reg);
                        edge_reg    <= edge_reg + CW'(1);
                    end
                end
                S_EMIT:   emit_reg <= emit_reg + 3'd1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_TAKE_A: a_reg <= rd_q;
            S_EDGE:
            begin
                xin_reg <= xin;
                t_reg   <= (t_zero || cin == xin) ? '0 :
                           (an >= ad) ? 31'(1 << qnpc_pkg::T_FRAC) : '0;
            end
            S_DIV:    if (div_done) t_reg <= {1'b0, quot};
            S_MUL_ST:
            begin
                case (k_reg)
                    2'd0:    vbuf[n_reg].pos_x <= lres;
                    2'd1:    vbuf[n_reg].pos_y <= lres;
                    2'd2:    vbuf[n_reg].tex_u <= lres[16:0];
                    default:
                    begin
                        vbuf[n_reg].tex_v <= lres[16:0];
                        vbuf[n_reg].corner_depth_in <= {1'b0, near_reg};
                    end
                endcase
            end
            S_POST:
            begin
                if (xin_reg && room)
                    vbuf[n_reg] <= rd_q;
                a_reg <= rd_q;
            end
            default: ;
        endcase
    end

    // result drive
    always_comb
    begin
        result = '0;
        if (n_reg == '0)
        begin
            result.polygon_empty = 1'b1;
            result.last_vertex   = 1'b1;
        end
        else
        begin
            result.out_x        = vbuf[emit_reg].pos_x;
            result.out_y        = vbuf[emit_reg].pos_y;
            result.out_depth    = vbuf[emit_reg].corner_depth_in;
            result.out_u        = vbuf[emit_reg].tex_u;
            result.out_v        = vbuf[emit_reg].tex_v;
            result.last_vertex  = (emit_reg == n_reg - 3'd1);
            result.vertex_total = n_reg;
        end
    end

    assign result_valid = (state_reg == S_EMIT);
    assign busy = (state_reg != S_IDLE);

endmodule

// File: tb/sv/quad_near_plane_clipper_test.sv
// Self-checking testbench for the quad near-plane clipper: directed and random corners against a built-in predictor.
module quad_near_plane_clipper_test;

    localparam int NCORN = 4;
    localparam int T_SHIFT = 30;
    localparam longint T_UNIT = 64'sd1 << T_SHIFT;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    qnpc_pkg::corner_t corner = '0;
    logic cfg_we = 1'b0;
    logic [qnpc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [qnpc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic result_valid;
    qnpc_pkg::result_t result;

    quad_near_plane_clipper uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .corner(corner),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .result(result)
    );

    always #2 clk = ~clk;

    // predictor state
    longint plane_depth = 65536;
    longint flat_eps = 7;
    qnpc_pkg::corner_t held [NCORN];
    int held_count = 0;

    qnpc_pkg::corner_t pending_corners[$];
    qnpc_pkg::result_t expected_vertices[$];
    int mismatches = 0;
    int cycles = 0;
    bit gaps_on = 1'b1;
    int gap_left = 0;
    logic busy_at_edge = 1'b0;

    function automatic longint ratio_t(longint d0, longint d1);
        longint num, den, an, ad;
        num = plane_depth - d0;
        den = d1 - d0;
        ad = den < 0 ? -den : den;
        if (ad <= flat_eps) return 0;
        if (num == 0 || ((num < 0) != (den < 0))) return 0;
        an = num < 0 ? -num : num;
        if (an >= ad) return T_UNIT;
        return (an << T_SHIFT) / ad;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        longint p;
        p = (b - a) * t;
        if (p >= 0) return a + (p >>> T_SHIFT);
        return a - ((-p) >>> T_SHIFT);
    endfunction

    function automatic qnpc_pkg::result_t vertex_of(longint x, longint y, longint d,
                                                    longint u, longint v);
        qnpc_pkg::result_t r;
        r = '0;
        r.out_x = x[31:0];
        r.out_y = y[31:0];
        r.out_depth = d[31:0];
        r.out_u = u[16:0];
        r.out_v = v[16:0];
        return r;
    endfunction

    task automatic clip_corner(qnpc_pkg::corner_t c);
        qnpc_pkg::result_t verts[$];
        int j;
        longint dc, dn, t;
        bit cin, nin;
        held[held_count] = c;
        held_count++;
        if (held_count < NCORN) return;
        held_count = 0;
        for (int i = 0; i < NCORN; i++) begin
            j = (i + 1) % NCORN;
            dc = longint'(held[i].corner_depth_in);
            dn = longint'(held[j].corner_depth_in);
            cin = dc > plane_depth;
            nin = dn > plane_depth;
            if (cin != nin && verts.size() < qnpc_pkg::MAX_OUT) begin
                t = ratio_t(dc, dn);
                verts = {verts, vertex_of(
                    blend(longint'(held[i].pos_x), longint'(held[j].pos_x), t),
                    blend(longint'(held[i].pos_y), longint'(held[j].pos_y), t),
                    plane_depth,
                    blend(longint'(held[i].tex_u), longint'(held[j].tex_u), t),
                    blend(longint'(held[i].tex_v), longint'(held[j].tex_v), t))};
            end
            if (nin && verts.size() < qnpc_pkg::MAX_OUT)
                verts = {verts, vertex_of(longint'(held[j].pos_x),
                    longint'(held[j].pos_y), dn, longint'(held[j].tex_u),
                    longint'(held[j].tex_v))};
        end
        if (verts.size() == 0) begin
            verts = {verts, vertex_of(0, 0, 0, 0, 0)};
            verts[0].polygon_empty = 1'b1;
        end else begin
            foreach (verts[k]) verts[k].vertex_total = 3'(verts.size());
        end
        verts[verts.size() - 1].last_vertex = 1'b1;
        foreach (verts[k]) expected_vertices = {expected_vertices, verts[k]};
    endtask

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (start && !busy_at_edge) begin
                if (pending_corners.size() > 0 && gap_left == 0) begin
                    corner <= pending_corners.pop_front();
                    start <= 1'b1;
                    if (gaps_on && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 4);
                end else
                    start <= 1'b0;
            end else if (!start) begin
                if (gap_left > 0) gap_left--;
                else if (pending_corners.size() > 0) begin
                    corner <= pending_corners.pop_front();
                    start <= 1'b1;
                    if (gaps_on && $urandom_range(0, 4) == 0)
                        gap_left = $urandom_range(1, 4);
                end
            end
        end
    end

    // accept tracking and result checking
    always @(posedge clk) begin
        qnpc_pkg::result_t want;
        cycles++;
        busy_at_edge = busy;
        if (rst_n && start && !busy)
            clip_corner(corner);
        if (rst_n && result_valid) begin
            if (expected_vertices.size() == 0) begin
                if (mismatches < 10) $display("unexpected result %p", result);
                mismatches++;
            end else begin
                want = expected_vertices.pop_front();
                if (result !== want) begin
                    if (mismatches < 10)
                        $display("mismatch: expected %p got %p", want, result);
                    mismatches++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("[quad_near_plane_clipper] ERROR");
            $finish;
        end
    end

    function automatic qnpc_pkg::corner_t rand_corner(longint near_ref, int mode);
        qnpc_pkg::corner_t c;
        c.pos_x = $urandom;
        c.pos_y = $urandom;
        c.tex_u = 17'($urandom_range(0, 65536));
        c.tex_v = 17'($urandom_range(0, 65536));
        case (mode)
            0: c.corner_depth_in = $urandom;
            1: c.corner_depth_in = 32'(near_ref + longint'($urandom_range(0, 8)) - 4);
            default: c.corner_depth_in = 32'(near_ref +
                       longint'($urandom_range(0, 400000)) - 200000);
        endcase
        if ($urandom_range(0, 9) == 0) begin
            c.tex_u = 17'($urandom);
            c.tex_v = 17'($urandom);
        end
        return c;
    endfunction

    task automatic wait_drained();
        while (pending_corners.size() > 0 || start || busy || expected_vertices.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [qnpc_pkg::CFG_IDX_W-1:0] idx,
                             logic [qnpc_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == qnpc_pkg::CFG_NEAR_DEPTH) plane_depth = longint'(val);
        else flat_eps = longint'(val[15:0]);
    endtask

    task automatic queue_quad(longint near_ref, int mode);
        for (int k = 0; k < NCORN; k++)
            pending_corners = {pending_corners, rand_corner(near_ref, mode)};
    endtask

    task automatic queue_depths(longint d0, longint d1, longint d2, longint d3);
        longint ds [4];
        qnpc_pkg::corner_t c;
        ds = '{d0, d1, d2, d3};
        foreach (ds[k]) begin
            c = rand_corner(0, 0);
            c.corner_depth_in = 32'(ds[k]);
            pending_corners = {pending_corners, c};
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // directed: all inside, all outside, one outside, alternating, extremes, near the plane
        queue_depths(200000, 300000, 400000, 500000);
        queue_depths(0, 65536, -5, 1000);
        queue_depths(10, 200000, 300000, 400000);
        queue_depths(200000, 10, 200000, 10);
        queue_depths(-64'sd2147483648, 2147483647, 2147483647, -64'sd2147483648);
        queue_depths(65537, 65530, 65540, 65536);
        wait_drained();
        write_reg(qnpc_pkg::CFG_NEAR_DEPTH, 31'd0);
        write_reg(qnpc_pkg::CFG_DEPTH_EPS, 31'h0000FFFF);
        queue_depths(0, 1, -1, 70000);
        queue_depths(-64'sd2147483648, 2147483647, 0, 100);
        for (int q = 0; q < 12; q++) queue_quad(0, q % 3);
        wait_drained();
        write_reg(qnpc_pkg::CFG_NEAR_DEPTH, 31'h7FFFFFFF);
        write_reg(qnpc_pkg::CFG_DEPTH_EPS, 31'd0);
        queue_depths(2147483647, 2147483647, -64'sd2147483648, 2147483647);
        for (int q = 0; q < 6; q++) queue_quad(64'h7FFFFFFF, q % 3);
        wait_drained();
        write_reg(qnpc_pkg::CFG_NEAR_DEPTH, 31'd65536);
        write_reg(qnpc_pkg::CFG_DEPTH_EPS, 31'd7);
        for (int q = 0; q < 7; q++) queue_quad(65536, q % 3);
        wait_drained();
        write_reg(qnpc_pkg::CFG_NEAR_DEPTH, 31'($urandom));
        write_reg(qnpc_pkg::CFG_DEPTH_EPS, 31'($urandom_range(0, 65535)));
        for (int q = 0; q < 10; q++) queue_quad(plane_depth, q % 3);
        pending_corners = {pending_corners, rand_corner(plane_depth, 2)};
        wait_drained();
        gaps_on = 1'b0;
        write_reg(qnpc_pkg::CFG_NEAR_DEPTH, 31'd131072);
        write_reg(qnpc_pkg::CFG_DEPTH_EPS, 31'd3);
        // finish the stray corner's quad first
        for (int k = 0; k < 3; k++)
            pending_corners = {pending_corners, rand_corner(131072, 2)};
        for (int q = 0; q < 8; q++) queue_quad(131072, q % 3);
        wait_drained();
        if (mismatches == 0 && expected_vertices.size() == 0)
            $display("[quad_near_plane_clipper] OK");
        else
            $display("[quad_near_plane_clipper] ERROR");
        $finish;
    end
endmodule
